>>> hw/rtl/swrl_pkg.sv
// shared constants, codes and helpers of the sliding window request limiter
`default_nettype none

package swrl_pkg;

  // stamp queue geometry
  localparam int unsigned QueueDepth = 10;
  localparam int unsigned PtrW       = 4;
  localparam int unsigned StampW     = 4;
  localparam int unsigned CountW     = 4;

  // admitted requests stay in the window for this many steps
  localparam logic [StampW-1:0] WindowSteps = StampW'(10);

  // limits per tier
  localparam logic [CountW-1:0] LimitTier0 = CountW'(3);
  localparam logic [CountW-1:0] LimitTier1 = CountW'(6);
  localparam logic [CountW-1:0] LimitTier2 = CountW'(9);

  // tier codes
  localparam logic [1:0] Tier0 = 2'd0;
  localparam logic [1:0] Tier1 = 2'd1;

  // verdict codes
  localparam logic [1:0] VerdictOther   = 2'd0;
  localparam logic [1:0] VerdictAdmit   = 2'd1;
  localparam logic [1:0] VerdictRefused = 2'd2;

  // configuration register indexes
  localparam logic CfgIdxTargetId = 1'b0;
  localparam logic CfgIdxTier     = 1'b1;

  typedef logic [PtrW-1:0]   ptr_t;
  typedef logic [StampW-1:0] stamp_t;
  typedef logic [CountW-1:0] count_t;

  // limit of held stamps for a tier; codes other than tier 0 and tier 1 get the tier 2 limit
  function automatic count_t tier_limit(input logic [1:0] tier);
    count_t lim;
    case (tier)
      Tier0:   lim = LimitTier0;
      Tier1:   lim = LimitTier1;
      default: lim = LimitTier2;
    endcase
    return lim;
  endfunction

  // queue pointer advance with wrap at the depth
  function automatic ptr_t ptr_advance(input ptr_t ptr);
    ptr_t nxt;
    if (ptr == PtrW'(QueueDepth - 1)) begin
      nxt = '0;
    end else begin
      nxt = ptr + PtrW'(1);
    end
    return nxt;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/sliding_window_request_limiter_top.sv
// A result is registered and presented in the cycle after its item is accepted.
// Throughput: one item per cycle while the output register is empty or being taken;
//   the head stamp is read from the stamp RAM into a register at the next head pointer, with write-to-read forwarding.
// s_axis_tready stays high while the output register is empty or being taken.
// Reset clears the step counter, queue pointers, held count and the config
//   registers; the stamp RAM is not cleared and is read only where written.
`default_nettype none

module sliding_window_request_limiter_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write port
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  // request stream
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] req_id
  input  wire logic        s_axis_tlast,   // end_of_batch
  // verdict stream
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [7:0]  m_axis_tdata,   // [1:0] verdict, [7:2] zero
  output      logic        m_axis_tlast    // last
);

  // configuration registers
  logic signed [31:0] target_id_q;
  logic [1:0]         tier_q;

  // queue control state
  swrl_pkg::stamp_t step_q, step_d;
  swrl_pkg::ptr_t   head_q, head_d;
  swrl_pkg::ptr_t   tail_q, tail_d;
  swrl_pkg::count_t count_q, count_d;

  // stamp RAM and its registered read side
  swrl_pkg::stamp_t mem_q [swrl_pkg::QueueDepth];
  swrl_pkg::stamp_t rd_data_q;
  swrl_pkg::stamp_t fwd_data_q;
  logic             fwd_hit_q;
  swrl_pkg::stamp_t head_stamp;

  // output register
  logic       out_valid_q;
  logic [1:0] verdict_q, verdict_d;
  logic       last_q;

  logic                in_accept;
  logic                expire;
  swrl_pkg::ptr_t      head_exp;
  swrl_pkg::count_t    count_exp;
  swrl_pkg::stamp_t    age;
  logic                push;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_id_q <= '0;
      tier_q      <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        swrl_pkg::CfgIdxTargetId: target_id_q <= cfg_data_i;
        swrl_pkg::CfgIdxTier:     tier_q      <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // head stamp with forwarding of a same-cycle write
  assign head_stamp = fwd_hit_q ? fwd_data_q : rd_data_q;

  // expiry of the oldest stamp
  always_comb begin
    age       = step_q - head_stamp;
    expire    = (count_q != '0) && (age >= swrl_pkg::WindowSteps);
    head_exp  = expire ? swrl_pkg::ptr_advance(head_q) : head_q;
    count_exp = expire ? count_q - swrl_pkg::CountW'(1) : count_q;
  end

  // verdict and next queue state
  always_comb begin
    push      = 1'b0;
    verdict_d = swrl_pkg::VerdictOther;
    if ($signed(s_axis_tdata) == target_id_q) begin
      if ((count_exp < swrl_pkg::tier_limit(tier_q)) &&
          (count_exp < swrl_pkg::CountW'(swrl_pkg::QueueDepth))) begin
        push      = 1'b1;
        verdict_d = swrl_pkg::VerdictAdmit;
      end else begin
        verdict_d = swrl_pkg::VerdictRefused;
      end
    end

    step_d  = step_q;
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (in_accept) begin
      if (s_axis_tlast) begin
        step_d  = '0;
        head_d  = '0;
        tail_d  = '0;
        count_d = '0;
      end else begin
        step_d  = step_q + swrl_pkg::StampW'(1);
        head_d  = head_exp;
        tail_d  = push ? swrl_pkg::ptr_advance(tail_q) : tail_q;
        count_d = push ? count_exp + swrl_pkg::CountW'(1) : count_exp;
      end
    end
  end

  // queue control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= '0;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      step_q  <= step_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // stamp RAM: write at tail, read next head
  always_ff @(posedge clk_i) begin
    if (in_accept && push) begin
      mem_q[tail_q] <= step_q;
    end
    rd_data_q <= mem_q[head_d];
  end

  // forwarding register for a write to the entry being read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
    end else begin
      fwd_hit_q <= in_accept && push && (tail_q == head_d);
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= step_q;
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      verdict_q <= verdict_d;
      last_q    <= s_axis_tlast;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, verdict_q};
  assign m_axis_tlast  = last_q;

endmodule

`default_nettype wire
